/* rtl/cau_pkg.sv */
package cau_pkg;

  // Q format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;          // one 32x32 product
  localparam int ACC_W     = PROD_W + 1;          // sum of two products
  localparam int NUM_W     = PROD_W + FRAC_BITS;  // scaled dividend
  localparam int QUO_W     = DATA_W + 1;          // quotient bits developed
  localparam int DSH_W     = PROD_W + QUO_W;      // shifted divisor
  localparam int STEP_W    = $clog2(QUO_W);

  // request queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  // one classified request
  typedef struct packed {
    cmd_t                      cmd;
    logic                      fast;      // finished in the back end's idle state
    logic                      zero_div;  // divide with zero divisor
    logic signed [DATA_W-1:0]  a_re;
    logic signed [DATA_W-1:0]  a_im;
    logic signed [DATA_W-1:0]  b_re;
    logic signed [DATA_W-1:0]  b_im;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } sat_t;

  // clamp a wide signed value to DATA_W bits
  function automatic sat_t sat_wide(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (&v[ACC_W-1:DATA_W-1] || ~|v[ACC_W-1:DATA_W-1]) begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end else if (v[ACC_W-1]) begin
      r.val = {1'b1, {(DATA_W-1){1'b0}}};
      r.sat = 1'b1;
    end else begin
      r.val = {1'b0, {(DATA_W-1){1'b1}}};
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // sign and truncated quotient magnitude to DATA_W bits
  function automatic sat_t div_pack(input logic neg, input logic ovf,
                                    input logic [QUO_W-1:0] q);
    sat_t r;
    if (!neg) begin
      if (ovf || q[QUO_W-1] || q[DATA_W-1]) begin
        r.val = {1'b0, {(DATA_W-1){1'b1}}};
        r.sat = 1'b1;
      end else begin
        r.val = q[DATA_W-1:0];
        r.sat = 1'b0;
      end
    end else begin
      if (ovf || q[QUO_W-1] || (q[DATA_W-1] && |q[DATA_W-2:0])) begin
        r.val = {1'b1, {(DATA_W-1){1'b0}}};
        r.sat = 1'b1;
      end else begin
        r.val = -q[DATA_W-1:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/complex_arithmetic_unit.sv */
// Complex add / subtract / multiply / divide on signed Q16.16 operands.
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for a single cycle with done high, and the
// receiver cannot stall it. Requests go into a four-deep queue, so busy only
// rises when that queue is full. Add, subtract and divide by zero finish in
// the idle state: one result per clock, unless a slower request is ahead.
// Multiply uses the shared 32x32 multiplier and accumulator (four products).
// Divide runs six products, then 33 restoring-division steps for both parts
// side by side. A fast request passes through the queue and the result
// registers before done, plus queueing behind slower ones. status is
// 0 ok, 1 saturated, 2 divide by zero (result zero).
module complex_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic signed [cau_pkg::DATA_W-1:0]   a_re,
  input  logic signed [cau_pkg::DATA_W-1:0]   a_im,
  input  logic signed [cau_pkg::DATA_W-1:0]   b_re,
  input  logic signed [cau_pkg::DATA_W-1:0]   b_im,
  output logic                                done,
  output logic signed [cau_pkg::DATA_W-1:0]   res_re,
  output logic signed [cau_pkg::DATA_W-1:0]   res_im,
  output logic [1:0]                          status
);

  // queue head towards the execution side
  cau_pkg::req_t head;
  logic          head_valid;
  logic          pop;

  // front: take and classify requests, buffer them
  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .a_re       (a_re),
    .a_im       (a_im),
    .b_re       (b_re),
    .b_im       (b_im),
    .busy       (busy),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: execute, saturate, register the result
  cau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .done       (done),
    .res_re     (res_re),
    .res_im     (res_im),
    .status     (status)
  );

endmodule

/* rtl/cau_front.sv */
module cau_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          cmd,
  input  logic signed [cau_pkg::DATA_W-1:0]   a_re,
  input  logic signed [cau_pkg::DATA_W-1:0]   a_im,
  input  logic signed [cau_pkg::DATA_W-1:0]   b_re,
  input  logic signed [cau_pkg::DATA_W-1:0]   b_im,
  output logic                                busy,
  input  logic                                pop,
  output logic                                head_valid,
  output cau_pkg::req_t                       head
);

  cau_pkg::req_t                  q_mem [cau_pkg::QDEPTH];
  logic [cau_pkg::QPTR_W-1:0]     wr_ptr;
  logic [cau_pkg::QPTR_W-1:0]     rd_ptr;
  logic [cau_pkg::QCNT_W-1:0]     count;
  cau_pkg::req_t                  req;
  logic                           push;
  logic                           take;

  // classify
  always_comb begin
    req.cmd      = cau_pkg::cmd_t'(cmd);
    req.zero_div = (req.cmd == cau_pkg::CMD_DIV) && (b_re == '0) && (b_im == '0);
    req.fast     = (req.cmd == cau_pkg::CMD_ADD) || (req.cmd == cau_pkg::CMD_SUB) ||
                   req.zero_div;
    req.a_re     = a_re;
    req.a_im     = a_im;
    req.b_re     = b_re;
    req.b_im     = b_im;
  end

  assign busy       = (count == cau_pkg::QCNT_W'(cau_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = q_mem[rd_ptr];
  assign push       = start && !busy;
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cau_pkg::QPTR_W'(cau_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == cau_pkg::QPTR_W'(cau_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/cau_back.sv */
module cau_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  cau_pkg::req_t                       head,
  output logic                                pop,
  output logic                                done,
  output logic signed [cau_pkg::DATA_W-1:0]   res_re,
  output logic signed [cau_pkg::DATA_W-1:0]   res_im,
  output logic [1:0]                          status
);

  localparam int DATA_W = cau_pkg::DATA_W;
  localparam int PROD_W = cau_pkg::PROD_W;
  localparam int ACC_W  = cau_pkg::ACC_W;
  localparam int NUM_W  = cau_pkg::NUM_W;
  localparam int QUO_W  = cau_pkg::QUO_W;
  localparam int DSH_W  = cau_pkg::DSH_W;
  localparam int STEP_W = cau_pkg::STEP_W;
  localparam int FRAC   = cau_pkg::FRAC_BITS;
  localparam int MUL_PRODUCTS = 4;
  localparam int DIV_PRODUCTS = 6;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_PROD    = 6'b000010,
    S_DRAIN   = 6'b000100,
    S_DIVPREP = 6'b001000,
    S_DIV     = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    D_RE_ADD,
    D_RE_SUB,
    D_IM_ADD,
    D_IM_SUB,
    D_DEN
  } dst_t;

  state_t                    state;
  cau_pkg::req_t             cur;
  logic [STEP_W-1:0]         cnt;
  logic [STEP_W-1:0]         last_step;
  logic signed [DATA_W-1:0]  mul_x;
  logic signed [DATA_W-1:0]  mul_y;
  dst_t                      mul_dst;
  logic signed [PROD_W-1:0]  prod;
  dst_t                      prod_dst;
  logic                      prod_vld;
  logic signed [ACC_W-1:0]   acc_re;
  logic signed [ACC_W-1:0]   acc_im;
  logic [PROD_W-1:0]         den;
  logic [NUM_W-1:0]          rem_re;
  logic [NUM_W-1:0]          rem_im;
  logic [DSH_W-1:0]          dsh;
  logic [QUO_W-1:0]          q_re;
  logic [QUO_W-1:0]          q_im;
  logic                      neg_re;
  logic                      neg_im;
  logic                      ovf_re;
  logic                      ovf_im;
  logic [PROD_W-1:0]         mag_re;
  logic [PROD_W-1:0]         mag_im;
  logic [NUM_W-1:0]          num_re;
  logic [NUM_W-1:0]          num_im;
  logic [DSH_W-1:0]          den_top;
  logic                      ge_re;
  logic                      ge_im;
  logic signed [ACC_W-1:0]   sum_re;
  logic signed [ACC_W-1:0]   sum_im;
  cau_pkg::sat_t             fast_re;
  cau_pkg::sat_t             fast_im;
  cau_pkg::sat_t             fin_re;
  cau_pkg::sat_t             fin_im;

  assign pop       = (state == S_IDLE);
  assign last_step = (cur.cmd == cau_pkg::CMD_MUL) ? STEP_W'(MUL_PRODUCTS - 1)
                                                   : STEP_W'(DIV_PRODUCTS - 1);

  // product schedule: mul (ac - bd, ad + bc), div (ac + bd, bc - ad, c^2 + d^2)
  always_comb begin
    mul_x   = cur.a_re;
    mul_y   = cur.b_re;
    mul_dst = D_RE_ADD;
    if (cur.cmd == cau_pkg::CMD_MUL) begin
      case (cnt)
        STEP_W'(1): begin mul_x = cur.a_im; mul_y = cur.b_im; mul_dst = D_RE_SUB; end
        STEP_W'(2): begin mul_x = cur.a_re; mul_y = cur.b_im; mul_dst = D_IM_ADD; end
        STEP_W'(3): begin mul_x = cur.a_im; mul_y = cur.b_re; mul_dst = D_IM_ADD; end
        default: ;
      endcase
    end else begin
      case (cnt)
        STEP_W'(1): begin mul_x = cur.a_im; mul_y = cur.b_im; mul_dst = D_RE_ADD; end
        STEP_W'(2): begin mul_x = cur.a_im; mul_y = cur.b_re; mul_dst = D_IM_ADD; end
        STEP_W'(3): begin mul_x = cur.a_re; mul_y = cur.b_im; mul_dst = D_IM_SUB; end
        STEP_W'(4): begin mul_x = cur.b_re; mul_y = cur.b_re; mul_dst = D_DEN;    end
        STEP_W'(5): begin mul_x = cur.b_im; mul_y = cur.b_im; mul_dst = D_DEN;    end
        default: ;
      endcase
    end
  end

  // combinational add/sub on the queue head
  always_comb begin
    if (head.cmd == cau_pkg::CMD_SUB) begin
      sum_re = ACC_W'($signed(head.a_re)) - ACC_W'($signed(head.b_re));
      sum_im = ACC_W'($signed(head.a_im)) - ACC_W'($signed(head.b_im));
    end else begin
      sum_re = ACC_W'($signed(head.a_re)) + ACC_W'($signed(head.b_re));
      sum_im = ACC_W'($signed(head.a_im)) + ACC_W'($signed(head.b_im));
    end
    fast_re = cau_pkg::sat_wide(sum_re);
    fast_im = cau_pkg::sat_wide(sum_im);
  end

  // divider set-up and one restoring step per cycle
  always_comb begin
    mag_re  = acc_re[ACC_W-1] ? PROD_W'(-acc_re) : PROD_W'(acc_re);
    mag_im  = acc_im[ACC_W-1] ? PROD_W'(-acc_im) : PROD_W'(acc_im);
    num_re  = {mag_re, {FRAC{1'b0}}};
    num_im  = {mag_im, {FRAC{1'b0}}};
    den_top = DSH_W'(den) << QUO_W;
    ge_re   = (DSH_W'(rem_re) >= dsh);
    ge_im   = (DSH_W'(rem_im) >= dsh);
  end

  // final packing
  always_comb begin
    if (cur.cmd == cau_pkg::CMD_MUL) begin
      fin_re = cau_pkg::sat_wide(acc_re >>> FRAC);
      fin_im = cau_pkg::sat_wide(acc_im >>> FRAC);
    end else begin
      fin_re = cau_pkg::div_pack(neg_re, ovf_re, q_re);
      fin_im = cau_pkg::div_pack(neg_im, ovf_im, q_im);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      prod_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            cnt <= '0;
            if (head.fast) begin
              done <= 1'b1;
            end else begin
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          prod_vld <= 1'b1;
          if (cnt == last_step) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= (cur.cmd == cau_pkg::CMD_MUL) ? S_FIN : S_DIVPREP;
        end
        S_DIVPREP: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == STEP_W'(QUO_W - 1)) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          cur    <= head;
          acc_re <= '0;
          acc_im <= '0;
          den    <= '0;
          if (head.zero_div) begin
            res_re <= '0;
            res_im <= '0;
            status <= cau_pkg::ST_DIVZ;
          end else begin
            res_re <= fast_re.val;
            res_im <= fast_im.val;
            status <= (fast_re.sat || fast_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
          end
        end
      end
      S_PROD: begin
        prod     <= mul_x * mul_y;
        prod_dst <= mul_dst;
      end
      S_DIVPREP: begin
        neg_re <= acc_re[ACC_W-1];
        neg_im <= acc_im[ACC_W-1];
        ovf_re <= (DSH_W'(num_re) >= den_top);
        ovf_im <= (DSH_W'(num_im) >= den_top);
        rem_re <= num_re;
        rem_im <= num_im;
        dsh    <= DSH_W'(den) << (QUO_W - 1);
        q_re   <= '0;
        q_im   <= '0;
      end
      S_DIV: begin
        if (ge_re) begin
          rem_re <= rem_re - dsh[NUM_W-1:0];
        end
        if (ge_im) begin
          rem_im <= rem_im - dsh[NUM_W-1:0];
        end
        q_re <= {q_re[QUO_W-2:0], ge_re};
        q_im <= {q_im[QUO_W-2:0], ge_im};
        dsh  <= dsh >> 1;
      end
      S_FIN: begin
        res_re <= fin_re.val;
        res_im <= fin_im.val;
        status <= (fin_re.sat || fin_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      default: ;
    endcase

    // accumulate the product issued in the previous cycle
    if (prod_vld) begin
      case (prod_dst)
        D_RE_ADD: acc_re <= acc_re + ACC_W'(prod);
        D_RE_SUB: acc_re <= acc_re - ACC_W'(prod);
        D_IM_ADD: acc_im <= acc_im + ACC_W'(prod);
        D_IM_SUB: acc_im <= acc_im - ACC_W'(prod);
        D_DEN:    den    <= den + $unsigned(prod);
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN || state == S_IDLE))
    else $error("result strobe without a finishing state");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0))
    else $error("long division entered with zero divisor");

  a_fin_ret: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (done && state == S_IDLE))
    else $error("finish did not deliver a result");
`endif

endmodule
